@@ hw/rtl/psst_pkg.sv @@
// Shared types and codes of the subscription table.
package psst_pkg;

  typedef logic [31:0] agent_t;
  typedef logic [63:0] topic_t;
  typedef logic [15:0] conn_t;
  typedef logic [4:0]  entry_idx_t;

  localparam int TopicW   = 64;
  localparam int AgentW   = 32;
  localparam int ConnW    = 16;
  // deliveries per publish are capped; the counter holds the cap itself
  localparam int MaxDeliver = 32;
  localparam int DelivW     = 6;

  typedef enum logic [1:0] {
    OP_SUBSCRIBE   = 2'd0,
    OP_UNSUBSCRIBE = 2'd1,
    OP_PUBLISH     = 2'd2,
    OP_REPORT_FAIL = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    KIND_SUBSCRIBED   = 3'd0,
    KIND_FULL         = 3'd1,
    KIND_UNSUBSCRIBED = 3'd2,
    KIND_NOT_FOUND    = 3'd3,
    KIND_DELIVER      = 3'd4,
    KIND_DONE         = 3'd5
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    conn_t      dest_conn;
    entry_idx_t entry_index;
    logic       last;
  } result_t;

endpackage

@@ hw/rtl/psst_if.sv @@
// Request and result channel interfaces of the subscription table.
interface psst_in_if;
  logic                 valid;
  logic                 ready;
  psst_pkg::op_t        op;
  psst_pkg::agent_t     agent;
  psst_pkg::topic_t     topic_key;
  psst_pkg::conn_t      conn_id;
  psst_pkg::entry_idx_t failed_index;

  modport source (output valid, op, agent, topic_key, conn_id, failed_index,
                  input ready);
  modport sink (input valid, op, agent, topic_key, conn_id, failed_index,
                output ready);
endinterface

interface psst_out_if;
  logic                 valid;
  logic                 ready;
  psst_pkg::kind_t      kind;
  psst_pkg::conn_t      dest_conn;
  psst_pkg::entry_idx_t entry_index;
  logic                 last;

  modport source (output valid, kind, dest_conn, entry_index, last, input ready);
  modport sink (input valid, kind, dest_conn, entry_index, last, output ready);
endinterface

@@ hw/rtl/psst_out_reg.sv @@
// Result output register: holds one word until the sink takes it.
module psst_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  psst_pkg::result_t res,
  output logic              free,
  psst_out_if.source        out_bus
);

  logic              valid_r;
  psst_pkg::result_t data_r;

  assign free = !valid_r || out_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res;
    end
  end

  assign out_bus.valid       = valid_r;
  assign out_bus.kind        = data_r.kind;
  assign out_bus.dest_conn   = data_r.dest_conn;
  assign out_bus.entry_index = data_r.entry_index;
  assign out_bus.last        = data_r.last;

endmodule

@@ hw/rtl/pubsub_subscription_table.sv @@
// Publish/subscribe subscription table: top level.
//
// Entries (agent, topic key, connection) sit in one synchronous RAM of
// TABLE_ENTRIES words and are only appended; active marks are flops cleared
// by reset. Subscribe and report-failure complete in the cycle they are
// accepted (one result word for subscribe, none for report-failure).
// Unsubscribe and publish walk the RAM one entry per cycle from entry 0,
// through its single read port, while the result sink does not stall.
// Unsubscribe stops at its first hit. Publish gives one deliver word per
// active, matching entry not owned by the sender (at most 32), then a done
// word carrying last. A topic key of zero in the table matches every topic;
// only the low 8*TOPIC_BYTES bits of a topic key are kept. No new request
// is taken while a walk runs.
module pubsub_subscription_table #(
  parameter int TABLE_ENTRIES = 32,
  parameter int TOPIC_BYTES   = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  psst_in_if.sink    in_bus,
  psst_out_if.source out_bus
);

  localparam int IdxW     = $clog2(TABLE_ENTRIES);
  localparam int CntW     = $clog2(TABLE_ENTRIES + 1);
  localparam int TopicBits = 8 * TOPIC_BYTES;
  localparam int EntryW   = psst_pkg::AgentW + TopicBits + psst_pkg::ConnW;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_SCAN
  } state_t;

  // entry RAM: {agent, topic, conn}
  logic [EntryW-1:0] mem [TABLE_ENTRIES];
  logic [EntryW-1:0] rd_data_r;
  logic              rd_en;
  logic [IdxW-1:0]   rd_addr;
  logic              wr_en;
  logic [IdxW-1:0]   wr_addr;
  logic [EntryW-1:0] wr_data;

  state_t                      state_r, state_nxt;
  logic [CntW-1:0]             count_r, count_nxt;
  logic [TABLE_ENTRIES-1:0]    active_r, active_nxt;
  psst_pkg::op_t               req_op_r, req_op_nxt;
  psst_pkg::agent_t            req_agent_r, req_agent_nxt;
  logic [TopicBits-1:0]        req_topic_r, req_topic_nxt;
  logic [CntW-1:0]             issue_r, issue_nxt;
  logic                        cmp_valid_r, cmp_valid_nxt;
  logic [IdxW-1:0]             cmp_idx_r, cmp_idx_nxt;
  logic [psst_pkg::DelivW-1:0] deliv_r, deliv_nxt;

  // output stage
  logic              out_load;
  logic              out_free;
  psst_pkg::result_t out_res;

  // compared entry fields
  psst_pkg::agent_t     ent_agent;
  logic [TopicBits-1:0] ent_topic;
  psst_pkg::conn_t      ent_conn;
  logic                 unsub_hit;
  logic                 pub_hit;
  logic                 accept;
  logic [TopicBits-1:0] in_topic;

  assign ent_agent = rd_data_r[EntryW-1 -: psst_pkg::AgentW];
  assign ent_topic = rd_data_r[psst_pkg::ConnW +: TopicBits];
  assign ent_conn  = rd_data_r[psst_pkg::ConnW-1:0];
  assign in_topic  = in_bus.topic_key[TopicBits-1:0];

  assign in_bus.ready = (state_r == ST_IDLE) && out_free;
  assign accept       = in_bus.valid && in_bus.ready;

  assign unsub_hit = (req_op_r == psst_pkg::OP_UNSUBSCRIBE) &&
                     (ent_agent == req_agent_r) && (ent_topic == req_topic_r);
  assign pub_hit   = (req_op_r == psst_pkg::OP_PUBLISH) && active_r[cmp_idx_r] &&
                     ((ent_topic == '0) || (ent_topic == req_topic_r)) &&
                     (ent_agent != req_agent_r) &&
                     (deliv_r < psst_pkg::DelivW'(psst_pkg::MaxDeliver));

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    active_nxt    = active_r;
    req_op_nxt    = req_op_r;
    req_agent_nxt = req_agent_r;
    req_topic_nxt = req_topic_r;
    issue_nxt     = issue_r;
    cmp_valid_nxt = cmp_valid_r;
    cmp_idx_nxt   = cmp_idx_r;
    deliv_nxt     = deliv_r;
    rd_en         = 1'b0;
    rd_addr       = issue_r[IdxW-1:0];
    wr_en         = 1'b0;
    wr_addr       = count_r[IdxW-1:0];
    wr_data       = {in_bus.agent, in_topic, in_bus.conn_id};
    out_load      = 1'b0;
    out_res       = '{kind: psst_pkg::KIND_DONE, dest_conn: '0, entry_index: '0,
                      last: 1'b1};

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_bus.op)
            psst_pkg::OP_SUBSCRIBE: begin
              out_load = 1'b1;
              if (count_r >= CntW'(TABLE_ENTRIES)) begin
                out_res.kind = psst_pkg::KIND_FULL;
              end else begin
                wr_en                         = 1'b1;
                active_nxt[count_r[IdxW-1:0]] = 1'b1;
                count_nxt                     = count_r + 1'b1;
                out_res.kind                  = psst_pkg::KIND_SUBSCRIBED;
                out_res.entry_index           = psst_pkg::entry_idx_t'(count_r);
              end
            end
            psst_pkg::OP_UNSUBSCRIBE, psst_pkg::OP_PUBLISH: begin
              req_op_nxt    = in_bus.op;
              req_agent_nxt = in_bus.agent;
              req_topic_nxt = in_topic;
              issue_nxt     = '0;
              cmp_valid_nxt = 1'b0;
              deliv_nxt     = '0;
              state_nxt     = ST_SCAN;
            end
            psst_pkg::OP_REPORT_FAIL: begin
              // ignored beyond the filled part of the table
              if (32'(in_bus.failed_index) < 32'(count_r)) begin
                active_nxt[IdxW'(in_bus.failed_index)] = 1'b0;
              end
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (cmp_valid_r && unsub_hit) begin
          // first match ends the walk, active or not
          if (out_free) begin
            out_load               = 1'b1;
            out_res.kind           = psst_pkg::KIND_UNSUBSCRIBED;
            out_res.entry_index    = psst_pkg::entry_idx_t'(cmp_idx_r);
            active_nxt[cmp_idx_r]  = 1'b0;
            cmp_valid_nxt          = 1'b0;
            state_nxt              = ST_IDLE;
          end
        end else if (!(cmp_valid_r && pub_hit) || out_free) begin
          // pipeline moves on: consume compared entry, fetch next one
          if (cmp_valid_r && pub_hit) begin
            out_load            = 1'b1;
            out_res.kind        = psst_pkg::KIND_DELIVER;
            out_res.dest_conn   = ent_conn;
            out_res.entry_index = psst_pkg::entry_idx_t'(cmp_idx_r);
            out_res.last        = 1'b0;
            deliv_nxt           = deliv_r + 1'b1;
          end
          if (issue_r < count_r) begin
            rd_en         = 1'b1;
            cmp_valid_nxt = 1'b1;
            cmp_idx_nxt   = issue_r[IdxW-1:0];
            issue_nxt     = issue_r + 1'b1;
          end else if (cmp_valid_r) begin
            cmp_valid_nxt = 1'b0;
          end else if (out_free) begin
            // walk finished: closing word
            out_load     = 1'b1;
            out_res.kind = (req_op_r == psst_pkg::OP_PUBLISH) ?
                           psst_pkg::KIND_DONE : psst_pkg::KIND_NOT_FOUND;
            state_nxt    = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      active_r    <= '0;
      issue_r     <= '0;
      cmp_valid_r <= 1'b0;
      deliv_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      active_r    <= active_nxt;
      issue_r     <= issue_nxt;
      cmp_valid_r <= cmp_valid_nxt;
      deliv_r     <= deliv_nxt;
    end
  end

  // request payload, no reset needed
  always_ff @(posedge clk) begin
    req_op_r    <= req_op_nxt;
    req_agent_r <= req_agent_nxt;
    req_topic_r <= req_topic_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
  end

  // entry RAM, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  psst_out_reg u_out_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (out_load),
    .res     (out_res),
    .free    (out_free),
    .out_bus (out_bus)
  );

endmodule

@@ verif/pubsub_subscription_table_test.sv @@
// Self-checking testbench for the publish/subscribe subscription table.
module pubsub_subscription_table_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_ENTRIES = 32;
  localparam int TOPIC_BYTES   = 8;
  // only the low 8*TOPIC_BYTES bits of a topic key survive in the table
  localparam psst_pkg::topic_t TopicMask = (TOPIC_BYTES == 8) ? '1 :
                                           ((64'd1 << (8 * TOPIC_BYTES)) - 64'd1);
  // a few fixed topics so that publishers and subscribers actually meet
  localparam psst_pkg::topic_t TopicA   = 64'h0000_6e6f_6465_2e61;
  localparam psst_pkg::topic_t TopicB   = 64'h0000_6e6f_6465_2e62;
  localparam psst_pkg::topic_t TopicAll = '0;
  localparam int RandomWords   = 210;
  localparam int HoldCycles    = 300;
  localparam int IdleLimit     = 2000;
  localparam int SettleCycles  = 40;

  // Mirror of the table plus the queue of result words still owed by the block.
  class subscription_scoreboard;
    bit                 active_of [TABLE_ENTRIES];
    psst_pkg::agent_t   agent_of  [TABLE_ENTRIES];
    psst_pkg::topic_t   topic_of  [TABLE_ENTRIES];
    psst_pkg::conn_t    conn_of   [TABLE_ENTRIES];
    int unsigned        fill;
    psst_pkg::result_t  owed_words[$];
    int unsigned errors, words_seen, requests;
    int unsigned deliveries, full_hits, not_found_hits, unsub_hits, max_fanout;

    function void owe(psst_pkg::kind_t kind, psst_pkg::conn_t conn, int idx, bit last);
      psst_pkg::result_t w;
      w.kind        = kind;
      w.dest_conn   = conn;
      w.entry_index = psst_pkg::entry_idx_t'(idx);
      w.last        = last;
      owed_words.push_back(w);
    endfunction

    // Works out every word one accepted request causes and updates the mirror.
    function void note_request(psst_pkg::op_t op, psst_pkg::agent_t agent,
                               psst_pkg::topic_t topic, psst_pkg::conn_t conn,
                               psst_pkg::entry_idx_t fidx);
      psst_pkg::topic_t key;
      int               hits;
      bit               found;
      key = topic & TopicMask;
      hits = 0;
      found = 1'b0;
      requests++;
      case (op)
        psst_pkg::OP_SUBSCRIBE: begin
          if (fill >= TABLE_ENTRIES) begin
            owe(psst_pkg::KIND_FULL, '0, 0, 1'b1);
            full_hits++;
          end else begin
            agent_of[fill]  = agent;
            topic_of[fill]  = key;
            conn_of[fill]   = conn;
            active_of[fill] = 1'b1;
            owe(psst_pkg::KIND_SUBSCRIBED, '0, fill, 1'b1);
            fill++;
          end
        end
        psst_pkg::OP_UNSUBSCRIBE: begin
          // first agent/topic hit wins, whether or not it is still active
          for (int i = 0; i < fill && !found; i++) begin
            if (agent_of[i] == agent && topic_of[i] == key) begin
              active_of[i] = 1'b0;
              owe(psst_pkg::KIND_UNSUBSCRIBED, '0, i, 1'b1);
              found = 1'b1;
              unsub_hits++;
            end
          end
          if (!found) begin
            owe(psst_pkg::KIND_NOT_FOUND, '0, 0, 1'b1);
            not_found_hits++;
          end
        end
        psst_pkg::OP_PUBLISH: begin
          for (int i = 0; i < fill; i++) begin
            if (active_of[i] && (topic_of[i] == TopicAll || topic_of[i] == key) &&
                agent_of[i] != agent) begin
              if (hits < psst_pkg::MaxDeliver)
                owe(psst_pkg::KIND_DELIVER, conn_of[i], i, 1'b0);
              hits++;
            end
          end
          deliveries += hits;
          if (hits > max_fanout) max_fanout = hits;
          owe(psst_pkg::KIND_DONE, '0, 0, 1'b1);
        end
        psst_pkg::OP_REPORT_FAIL: begin
          // silent; an index past the filled part is simply ignored
          if (fidx < fill) active_of[fidx] = 1'b0;
        end
      endcase
    endfunction

    function bit field_ok(string name, int want, int got);
      if (want != got) begin
        $display("%0t: mismatch on %s: expected %0d, got %0d", $time, name, want, got);
        errors++;
      end
      return want == got;
    endfunction

    function void check_result(psst_pkg::result_t got);
      psst_pkg::result_t want;
      bit                ok;
      words_seen++;
      if (owed_words.size() == 0) begin
        $display("%0t: unexpected word: expected none, got kind %0d conn %0d entry %0d last %0d",
                 $time, got.kind, got.dest_conn, got.entry_index, got.last);
        errors++;
      end else begin
        want = owed_words.pop_front();
        ok = field_ok("kind", int'(want.kind), int'(got.kind));
        ok = field_ok("dest_conn", want.dest_conn, got.dest_conn) && ok;
        ok = field_ok("entry_index", want.entry_index, got.entry_index) && ok;
        ok = field_ok("last", want.last, got.last) && ok;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  psst_in_if  in_bus();
  psst_out_if out_bus();

  pubsub_subscription_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .TOPIC_BYTES  (TOPIC_BYTES)
  ) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus)
  );

  subscription_scoreboard sb;
  bit quiet_phase;     // both sides stop idling while set
  bit hold_results;    // asks the result side for one long stall
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Monitor: check result words first, then note the request taken at the
  // same edge. Everything is sampled before the edge's updates land.
  // Also the watchdog: too long without any word moving ends the run.
  always @(posedge clk) begin
    if (out_bus.valid && out_bus.ready)
      sb.check_result({out_bus.kind, out_bus.dest_conn, out_bus.entry_index, out_bus.last});
    if (in_bus.valid && in_bus.ready)
      sb.note_request(in_bus.op, in_bus.agent, in_bus.topic_key, in_bus.conn_id,
                      in_bus.failed_index);
    if ((out_bus.valid && out_bus.ready) || (in_bus.valid && in_bus.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: no word moved for %0d cycles", $time, IdleLimit);
        $display("FAIL pubsub_subscription_table");
        $finish;
      end
    end
  end

  // Result side: random stall before each word, one long hold-off on request.
  initial begin
    int gap;
    out_bus.ready = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_results) begin
        gap = HoldCycles;
        hold_results = 1'b0;
      end else begin
        gap = quiet_phase ? 0 : $urandom_range(0, 15);
      end
      if (gap > 0) begin
        out_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!(out_bus.valid && out_bus.ready));
    end
  end

  // Offers one request word after a random gap and waits until it is taken.
  task automatic send_request(psst_pkg::op_t op, psst_pkg::agent_t agent,
                              psst_pkg::topic_t topic, psst_pkg::conn_t conn,
                              psst_pkg::entry_idx_t fidx);
    int gap;
    gap = quiet_phase ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.op           <= op;
    in_bus.agent        <= agent;
    in_bus.topic_key    <= topic;
    in_bus.conn_id      <= conn;
    in_bus.failed_index <= fidx;
    in_bus.valid        <= 1'b1;
    do @(posedge clk); while (!(in_bus.valid && in_bus.ready));
  endtask

  // Mostly a small pool so that agents collide, now and then any value.
  function automatic psst_pkg::agent_t pick_agent();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    return psst_pkg::agent_t'($urandom_range(1, 3));
      4:       return psst_pkg::agent_t'($urandom_range(1, 3));
      default: return (($urandom_range(0, 1) == 0) ?
                       psst_pkg::agent_t'($urandom_range(1, 3)) :
                       psst_pkg::agent_t'($urandom));
    endcase
  endfunction

  function automatic psst_pkg::topic_t pick_topic();
    case ($urandom_range(0, 7))
      0:       return TopicAll;
      1:       return '1;
      2, 3:    return TopicA;
      4, 5:    return TopicB;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic psst_pkg::conn_t any_conn();
    return psst_pkg::conn_t'($urandom_range(0, 65535));
  endfunction

  function automatic psst_pkg::entry_idx_t any_index();
    return psst_pkg::entry_idx_t'($urandom_range(0, 31));
  endfunction

  initial begin
    int            pick;
    psst_pkg::op_t op;
    sb = new();
    quiet_phase  = 1'b0;
    hold_results = 1'b0;
    idle_cycles  = 0;
    rst_n = 1'b0;
    in_bus.valid        = 1'b0;
    in_bus.op           = psst_pkg::OP_SUBSCRIBE;
    in_bus.agent        = '0;
    in_bus.topic_key    = '0;
    in_bus.conn_id      = '0;
    in_bus.failed_index = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table first, then a handful of entries covering the
    // match-all topic, sender exclusion and the extremes of each field.
    send_request(psst_pkg::OP_PUBLISH, '0, TopicAll, any_conn(), any_index()); // done word only
    send_request(psst_pkg::OP_UNSUBSCRIBE, 32'd1, TopicA, any_conn(), any_index()); // not found
    send_request(psst_pkg::OP_REPORT_FAIL, 32'd1, TopicA, any_conn(), '0); // empty: ignored
    send_request(psst_pkg::OP_SUBSCRIBE, '0, TopicAll, 16'hFFFF, any_index());
    send_request(psst_pkg::OP_SUBSCRIBE, '1, '1, 16'h0000, any_index());
    send_request(psst_pkg::OP_SUBSCRIBE, 32'd1, TopicA, 16'h1234, any_index());
    send_request(psst_pkg::OP_SUBSCRIBE, 32'd2, TopicA, 16'h5555, any_index());
    send_request(psst_pkg::OP_PUBLISH, 32'd1, TopicA, any_conn(), any_index());
    send_request(psst_pkg::OP_PUBLISH, '0, '1, any_conn(), any_index());
    send_request(psst_pkg::OP_PUBLISH, 32'd3, TopicB, any_conn(), any_index());
    send_request(psst_pkg::OP_UNSUBSCRIBE, 32'd2, TopicA, any_conn(), any_index());
    // hits the now inactive entry
    send_request(psst_pkg::OP_UNSUBSCRIBE, 32'd2, TopicA, any_conn(), any_index());
    send_request(psst_pkg::OP_PUBLISH, 32'd3, TopicA, any_conn(), any_index());
    send_request(psst_pkg::OP_REPORT_FAIL, 32'd3, TopicA, any_conn(), 5'd2);
    send_request(psst_pkg::OP_REPORT_FAIL, 32'd3, TopicA, any_conn(), 5'd31); // past fill
    send_request(psst_pkg::OP_PUBLISH, 32'd3, TopicA, any_conn(), any_index());
    send_request(psst_pkg::OP_UNSUBSCRIBE, '0, TopicA, any_conn(), any_index()); // topic differs
    send_request(psst_pkg::OP_SUBSCRIBE, 32'd3, TopicAll, 16'hAAAA, 5'd31);
    send_request(psst_pkg::OP_PUBLISH, '1, '1, any_conn(), any_index());
    send_request(psst_pkg::OP_PUBLISH, 32'd2, {$urandom, $urandom}, any_conn(), any_index());

    // Random: subscribes are frequent enough to fill the table part-way
    // through, so later publishes fan out wide and later subscribes hit full.
    for (int n = 0; n < RandomWords; n++) begin
      if (n == 60) hold_results = 1'b1;   // results back up, input must stall
      quiet_phase = (n >= 90 && n < 120);
      if (n == 150) begin
        // let the block drain completely before carrying on; one edge first
        // so the last request taken is already noted
        in_bus.valid <= 1'b0;
        @(posedge clk);
        while (sb.owed_words.size() != 0) @(posedge clk);
      end
      pick = $urandom_range(0, 99);
      if (pick < 20)      op = psst_pkg::OP_SUBSCRIBE;
      else if (pick < 28) op = psst_pkg::OP_UNSUBSCRIBE;
      else if (pick < 36) op = psst_pkg::OP_REPORT_FAIL;
      else                op = psst_pkg::OP_PUBLISH;
      send_request(op, pick_agent(), pick_topic(), any_conn(), any_index());
    end
    in_bus.valid <= 1'b0;
    quiet_phase = 1'b0;

    @(posedge clk);
    while (sb.owed_words.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);

    $display("Covered %0d requests, %0d result words; %0d deliveries (widest fan-out %0d).",
             sb.requests, sb.words_seen, sb.deliveries, sb.max_fanout);
    $display("Table filled to %0d entries; %0d full, %0d unsubscribed, %0d not found.",
             sb.fill, sb.full_hits, sb.unsub_hits, sb.not_found_hits);
    if (sb.errors == 0 && sb.owed_words.size() == 0) begin
      $display("PASS pubsub_subscription_table");
    end else begin
      $display("FAIL pubsub_subscription_table");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/psst_pkg.sv
hw/rtl/psst_if.sv
hw/rtl/psst_out_reg.sv
hw/rtl/pubsub_subscription_table.sv
verif/pubsub_subscription_table_test.sv
